// File: rtl/ipshs_pkg.sv
// ipshs_pkg: shared types and constants of the ips patch header shift block
// used by ipshs_front, ipshs_fifo, ipshs_back and the top level
package ipshs_pkg;

    localparam logic [23:0] EOF_MARK   = 24'h454F46;
    localparam logic [23:0] MAX24      = 24'hFFFFFF;
    localparam logic [39:0] MAGIC_WORD = 40'h5041544348;
    localparam logic [23:0] HDR_RESET  = 24'd512;

    // configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_HDR  = 1'b1;

    // end of file status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_IPS = 2'd1;
    localparam logic [1:0] ST_NO_EOF  = 2'd2;
    localparam logic [1:0] ST_TAIL    = 2'd3;

    typedef enum logic [7:0] {
        PH_MAGIC = 8'b0000_0001,
        PH_REC   = 8'b0000_0010,
        PH_PASS  = 8'b0000_0100,
        PH_SKIP  = 8'b0000_1000,
        PH_TRUNC = 8'b0001_0000,
        PH_AFTER = 8'b0010_0000,
        PH_TAIL  = 8'b0100_0000,
        PH_BAD   = 8'b1000_0000
    } t_phase;

    // all results caused by one input byte
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      cnt;     // 0 means one status-only item
        logic [1:0]      status;
        logic            fin;     // end of file transaction
    } t_desc;

endpackage

// File: rtl/ipshs_front.sv
// ipshs_front: parses the patch stream, rebases offsets and builds at most one
// result descriptor per input byte; depends on ipshs_pkg
module ipshs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [23:0]          i_cfg_wdata,
    input  logic                 i_acc,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_end_of_file,
    output logic                 o_push,
    output ipshs_pkg::t_desc     o_desc
);
    import ipshs_pkg::*;

    logic        r_mode;
    logic [23:0] r_hdr;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_hb [8];
    logic [7:0]  hb_w [8];
    logic [3:0]  r_hc, n_hc;
    logic [23:0] r_off, n_off;
    logic [15:0] r_len, n_len;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_drop, n_drop;
    logic        r_eof, n_eof;
    logic        r_bad, n_bad;

    logic [7:0][7:0] ob;
    logic [3:0]  cnt;
    logic [1:0]  stat;
    logic        tail;

    // record decision arithmetic
    logic [15:0] len_sel;
    logic [24:0] s_ol, s_oh;
    logic [25:0] s_ohl;
    logic [23:0] d_oh, wrap_off;
    logic [15:0] cut_rm, cut_add, drop_rm;
    logic        keep, cut;
    logic [23:0] t_val, t_sub;
    logic [24:0] t_add;

    always_comb begin
        len_sel = (r_hc == 4'd7) ? {i_in_byte, r_hb[5]} : {r_hb[3], i_in_byte};
        if (r_hc == 4'd7) len_sel = {r_hb[5], r_hb[6]};
    end

    assign s_ol    = {1'b0, r_off} + {9'd0, len_sel};
    assign s_oh    = {1'b0, r_off} + {1'b0, r_hdr};
    assign s_ohl   = {1'b0, s_oh} + {10'd0, len_sel};
    assign d_oh    = r_off - r_hdr;
    assign cut_rm  = s_ol[15:0] - r_hdr[15:0];
    assign cut_add = 16'd0 - s_oh[15:0];
    assign drop_rm = r_hdr[15:0] - r_off[15:0];
    // keep: record survives, cut: record straddles the limit
    assign keep    = r_mode ? (s_ol > {1'b0, r_hdr}) : !s_oh[24];
    assign cut     = r_mode ? (r_off < r_hdr)
                            : ((s_ohl > 26'h1000000) || (s_ohl == 26'd0));
    assign t_val   = {r_hb[0], r_hb[1], i_in_byte};
    assign t_sub   = t_val - r_hdr;
    assign t_add   = {1'b0, t_val} + {1'b0, r_hdr};

    always_comb begin
        n_phase = r_phase;
        hb_w    = r_hb;
        n_hc    = r_hc;
        n_off   = r_off;
        n_len   = r_len;
        n_rem   = r_rem;
        n_drop  = r_drop;
        n_eof   = r_eof;
        n_bad   = r_bad;
        ob      = '0;
        cnt     = 4'd0;
        stat    = ST_OK;
        tail    = 1'b0;
        wrap_off = '0;
        if (i_acc) begin
            case (r_phase)
                PH_MAGIC: begin
                    hb_w[r_hc[2:0]] = i_in_byte;
                    n_hc = r_hc + 4'd1;
                    if (n_hc >= 4'd5) begin
                        if ({hb_w[0], hb_w[1], hb_w[2], hb_w[3], hb_w[4]} == MAGIC_WORD) begin
                            ob[0] = hb_w[0]; ob[1] = hb_w[1]; ob[2] = hb_w[2];
                            ob[3] = hb_w[3]; ob[4] = hb_w[4];
                            cnt = 4'd5;
                            n_phase = PH_REC;
                        end else begin
                            n_bad = 1'b1;
                            n_phase = PH_BAD;
                        end
                        n_hc = 4'd0;
                    end
                end
                PH_REC: begin
                    hb_w[r_hc[2:0]] = i_in_byte;
                    n_hc = r_hc + 4'd1;
                    if (n_hc == 4'd3) begin
                        n_off = {hb_w[0], hb_w[1], hb_w[2]};
                        if (n_off == EOF_MARK) begin
                            ob[0] = EOF_MARK[23:16]; ob[1] = EOF_MARK[15:8];
                            ob[2] = EOF_MARK[7:0];
                            cnt = 4'd3;
                            n_eof = 1'b1;
                            n_phase = PH_TRUNC;
                            n_hc = 4'd0;
                        end
                    end else if (n_hc == 4'd5) begin
                        n_len = {hb_w[3], hb_w[4]};
                        if (n_len != 16'd0) begin
                            n_hc = 4'd0;
                            if (!keep) begin
                                n_phase = PH_SKIP; n_drop = n_len; n_rem = 16'd0;
                            end else if (r_mode) begin
                                if (cut) begin
                                    ob[3] = cut_rm[15:8]; ob[4] = cut_rm[7:0];
                                    n_phase = PH_SKIP; n_drop = drop_rm; n_rem = cut_rm;
                                end else begin
                                    ob[0] = d_oh[23:16]; ob[1] = d_oh[15:8];
                                    ob[2] = d_oh[7:0];
                                    ob[3] = n_len[15:8]; ob[4] = n_len[7:0];
                                    n_phase = PH_PASS; n_rem = n_len; n_drop = 16'd0;
                                end
                                cnt = 4'd5;
                            end else begin
                                ob[0] = s_oh[23:16]; ob[1] = s_oh[15:8]; ob[2] = s_oh[7:0];
                                n_phase = PH_PASS;
                                if (cut) begin
                                    ob[3] = cut_add[15:8]; ob[4] = cut_add[7:0];
                                    n_rem = cut_add; n_drop = n_len - cut_add;
                                end else begin
                                    ob[3] = n_len[15:8]; ob[4] = n_len[7:0];
                                    n_rem = n_len; n_drop = 16'd0;
                                end
                                cnt = 4'd5;
                            end
                        end
                    end else if (n_hc >= 4'd8) begin
                        // rle record: offset, zero length, run length, value
                        if (keep) begin
                            ob[7] = hb_w[7];
                            cnt = 4'd8;
                            if (r_mode) begin
                                if (cut) begin
                                    ob[5] = cut_rm[15:8]; ob[6] = cut_rm[7:0];
                                end else begin
                                    ob[0] = d_oh[23:16]; ob[1] = d_oh[15:8];
                                    ob[2] = d_oh[7:0];
                                    ob[5] = len_sel[15:8]; ob[6] = len_sel[7:0];
                                end
                            end else begin
                                ob[0] = s_oh[23:16]; ob[1] = s_oh[15:8]; ob[2] = s_oh[7:0];
                                if (cut) begin
                                    ob[5] = cut_add[15:8]; ob[6] = cut_add[7:0];
                                end else begin
                                    ob[5] = len_sel[15:8]; ob[6] = len_sel[7:0];
                                end
                            end
                        end
                        n_phase = PH_REC;
                        n_hc = 4'd0;
                    end
                end
                PH_PASS: begin
                    ob[0] = i_in_byte;
                    cnt = 4'd1;
                    n_rem = r_rem - 16'd1;
                    if (n_rem == 16'd0) n_phase = (r_drop != 16'd0) ? PH_SKIP : PH_REC;
                end
                PH_SKIP: begin
                    n_drop = r_drop - 16'd1;
                    if (n_drop == 16'd0) n_phase = (r_rem != 16'd0) ? PH_PASS : PH_REC;
                end
                PH_TRUNC: begin
                    hb_w[r_hc[2:0]] = i_in_byte;
                    n_hc = r_hc + 4'd1;
                    if (n_hc >= 4'd3) begin
                        if (r_mode && (t_val >= r_hdr)) begin
                            ob[0] = t_sub[23:16]; ob[1] = t_sub[15:8]; ob[2] = t_sub[7:0];
                            cnt = 4'd3;
                        end else if (!r_mode && !t_add[24]) begin
                            ob[0] = t_add[23:16]; ob[1] = t_add[15:8]; ob[2] = t_add[7:0];
                            cnt = 4'd3;
                        end
                        n_hc = 4'd0;
                        n_phase = PH_AFTER;
                    end
                end
                PH_AFTER, PH_TAIL: begin
                    n_phase = PH_TAIL;
                end
                default: begin
                end
            endcase

            if (i_end_of_file) begin
                tail = (n_phase == PH_TAIL) || ((n_phase == PH_TRUNC) && (n_hc != 4'd0));
                if ((n_phase == PH_MAGIC) && (n_hc != 4'd0)) n_bad = 1'b1;
                if ((n_phase == PH_REC) && (n_hc != 4'd0)) begin
                    // flush the partial record, offset rebased with wrap
                    wrap_off = r_mode ? (n_off - r_hdr) : (n_off + r_hdr);
                    for (int k = 0; k < 8; k++) begin
                        if (k < 3 && n_hc >= 4'd3) begin
                            ob[k] = (k == 0) ? wrap_off[23:16] :
                                    (k == 1) ? wrap_off[15:8] : wrap_off[7:0];
                        end else if (k < int'(n_hc)) begin
                            ob[k] = hb_w[k];
                        end
                    end
                    cnt = n_hc;
                end
                if (n_bad || (n_phase == PH_MAGIC)) stat = ST_NOT_IPS;
                else if (!n_eof)                    stat = ST_NO_EOF;
                else if (tail)                      stat = ST_TAIL;
                else                                stat = ST_OK;
                n_phase = PH_MAGIC;
                n_hc    = 4'd0;
                n_off   = '0;
                n_len   = '0;
                n_rem   = '0;
                n_drop  = '0;
                n_eof   = 1'b0;
                n_bad   = 1'b0;
            end
        end
    end

    assign o_push        = i_acc && ((cnt != 4'd0) || i_end_of_file);
    assign o_desc.bytes  = ob;
    assign o_desc.cnt    = cnt;
    assign o_desc.status = stat;
    assign o_desc.fin    = i_end_of_file;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_hdr   <= HDR_RESET;
            r_phase <= PH_MAGIC;
            r_hc    <= '0;
            r_off   <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_drop  <= '0;
            r_eof   <= 1'b0;
            r_bad   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE: r_mode <= i_cfg_wdata[0];
                    CFG_HDR:  r_hdr  <= i_cfg_wdata;
                    default:  r_mode <= r_mode;
                endcase
            end
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_off   <= n_off;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_drop  <= n_drop;
            r_eof   <= n_eof;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hb <= hb_w;
    end

endmodule

// File: rtl/ipshs_fifo.sv
// ipshs_fifo: short descriptor queue between parser and output serializer
// depends on ipshs_pkg for the descriptor type
module ipshs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ipshs_pkg::t_desc     i_desc,
    input  logic                 i_pop,
    output ipshs_pkg::t_desc     o_desc,
    output logic                 o_empty,
    output logic                 o_full
);
    import ipshs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (i_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full descriptor queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty descriptor queue");

endmodule

// File: rtl/ipshs_back.sv
// ipshs_back: unpacks descriptors into single output transactions
// depends on ipshs_pkg for the descriptor type
module ipshs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipshs_pkg::t_desc     i_desc,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_run_last,
    output logic [1:0]           o_status
);
    import ipshs_pkg::*;

    logic       r_busy;
    t_desc      r_desc;
    logic [2:0] r_idx;
    logic       last_item, out_acc;

    assign last_item = (r_desc.cnt == 4'd0) || ({1'b0, r_idx} == r_desc.cnt - 4'd1);
    assign out_acc   = r_busy && !i_stall;
    assign o_pop     = !i_empty && (!r_busy || (out_acc && last_item));

    assign o_valid      = r_busy;
    assign o_byte_valid = (r_desc.cnt != 4'd0);
    assign o_out_byte   = o_byte_valid ? r_desc.bytes[r_idx] : 8'd0;
    assign o_run_last   = last_item;
    assign o_status     = (last_item && r_desc.fin) ? r_desc.status : ST_OK;

    always_ff @(posedge i_clk) begin
        if (o_pop) r_desc <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_acc) begin
            if (last_item) r_busy <= 1'b0;
            else           r_idx  <= r_idx + 3'd1;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_desc.cnt != 4'd0) |-> ({1'b0, r_idx} < r_desc.cnt))
        else $error("byte index past descriptor count");
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_run_last)
        else $error("status on a non-final transaction");

endmodule

// File: rtl/ips_patch_header_shift_top.sv
// ips_patch_header_shift_top: ips patch offset rebasing, top level
// depends on ipshs_pkg, ipshs_front, ipshs_fifo, ipshs_back
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_stall      i_in_byte, i_end_of_file
//   output   out        o_valid / i_stall      o_out_byte, o_byte_valid, o_run_last, o_status
//   config   in         i_cfg_we               i_cfg_index, i_cfg_wdata
//
// one input transaction per cycle while the descriptor queue has room
// each input byte yields 0 to 8 output transactions, one per cycle from the output stage while i_stall is low
// the output serializer sets the sustained rate: one output transaction per cycle while i_stall is low
// synchronous active-low reset; mode resets to add, header size to 512
// o_stall rises only when the queue of DEPTH descriptors is full
module ips_patch_header_shift_top #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_run_last,
    output logic [1:0]  o_status
);
    import ipshs_pkg::*;

    t_desc push_desc, head_desc;
    logic  push, pop, empty, full, in_acc;

    assign o_stall = full;
    assign in_acc  = i_valid && !full;

    ipshs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_acc         (in_acc),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_push        (push),
        .o_desc        (push_desc)
    );

    ipshs_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_desc  (head_desc),
        .o_empty (empty),
        .o_full  (full)
    );

    ipshs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (head_desc),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_status     (o_status)
    );

endmodule
